// File: rtl/core/lts_pkg.sv
// Shared types, character constants and lookup functions for the log timestamp parser.
package lts_pkg;

    // Configuration register indexes
    localparam logic CFG_FORMAT_KIND  = 1'b0;
    localparam logic CFG_CURRENT_YEAR = 1'b1;

    // Layout codes
    localparam logic FMT_WEB   = 1'b0;
    localparam logic FMT_SHELL = 1'b1;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NONE  = 8'h00;

    // Saturation limits and reset year
    localparam logic [13:0] YEAR_CAP   = 14'd9999;
    localparam logic [13:0] NUM_CAP    = 14'd99;
    localparam logic [13:0] YEAR_RESET = 14'd1970;

    // Last field position per layout
    localparam logic [2:0] LAST_FIELD_WEB   = 3'd5;
    localparam logic [2:0] LAST_FIELD_SHELL = 3'd4;
    localparam logic [2:0] MONTH_LEN_FULL   = 3'd3;
    localparam logic [2:0] MONTH_LEN_OVER   = 3'd4;

    typedef enum logic [2:0] {
        ROLE_DAY  = 3'd0,
        ROLE_MON  = 3'd1,
        ROLE_YEAR = 3'd2,
        ROLE_HOUR = 3'd3,
        ROLE_MIN  = 3'd4,
        ROLE_SEC  = 3'd5
    } role_t;

    // One parsed timestamp
    typedef struct packed {
        logic [6:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic        bad_digit;
    } result_t;

    // Three-letter month names, first letter in the high byte
    localparam logic [23:0] MONTH_NAMES [12] = '{
        24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072,
        24'h4D6179, 24'h4A756E, 24'h4A756C, 24'h417567,
        24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
    };

    function automatic logic [2:0] last_field(input logic fmt);
        last_field = (fmt == FMT_SHELL) ? LAST_FIELD_SHELL : LAST_FIELD_WEB;
    endfunction

    // What each field position holds in each layout
    function automatic role_t field_role(input logic fmt, input logic [2:0] fi);
        role_t r;
        r = ROLE_SEC;
        if (fmt == FMT_WEB)
        begin
            unique case (fi)
                3'd0:    r = ROLE_DAY;
                3'd1:    r = ROLE_MON;
                3'd2:    r = ROLE_YEAR;
                3'd3:    r = ROLE_HOUR;
                3'd4:    r = ROLE_MIN;
                default: r = ROLE_SEC;
            endcase
        end
        else
        begin
            unique case (fi)
                3'd0:    r = ROLE_MON;
                3'd1:    r = ROLE_DAY;
                3'd2:    r = ROLE_HOUR;
                3'd3:    r = ROLE_MIN;
                default: r = ROLE_SEC;
            endcase
        end
        return r;
    endfunction

    // Byte that closes each field position
    function automatic logic [7:0] field_sep(input logic fmt, input logic [2:0] fi);
        logic [7:0] s;
        s = CH_NONE;
        if (fmt == FMT_WEB)
        begin
            unique case (fi)
                3'd0, 3'd1:       s = CH_SLASH;
                3'd2, 3'd3, 3'd4: s = CH_COLON;
                default:          s = CH_NONE;
            endcase
        end
        else
        begin
            unique case (fi)
                3'd0, 3'd1: s = CH_SPACE;
                3'd2, 3'd3: s = CH_COLON;
                default:    s = CH_NONE;
            endcase
        end
        return s;
    endfunction

    // Month name to 1..12, 0 when unmatched or not exactly three bytes
    function automatic logic [3:0] decode_month(input logic [23:0] text,
                                                input logic [2:0] len);
        logic [3:0] m;
        m = 4'd0;
        if (len == MONTH_LEN_FULL)
        begin
            for (int i = 0; i < 12; i++)
            begin
                if (text == MONTH_NAMES[i])
                begin
                    m = 4'(i + 1);
                end
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/core/lts_parse.sv
// Per-byte field parser: working state, saved fields and the result for the final byte.
module lts_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        char_code,
    input  logic              is_last,
    input  logic              format_kind,
    input  logic [13:0]       current_year,
    output lts_pkg::result_t  result
);
    import lts_pkg::*;

    logic [2:0]  field_index_reg;
    logic [13:0] acc_reg;
    logic [23:0] month_text_reg;
    logic [2:0]  month_len_reg;
    logic [6:0]  saved_day_reg;
    logic [3:0]  saved_month_reg;
    logic [13:0] saved_year_reg;
    logic [6:0]  saved_hour_reg;
    logic [6:0]  saved_minute_reg;
    logic        digit_error_reg;

    // Values after this byte is applied
    logic [2:0]  field_index_next;
    logic [13:0] acc_next;
    logic [23:0] month_text_next;
    logic [2:0]  month_len_next;
    logic [6:0]  saved_day_next;
    logic [3:0]  saved_month_next;
    logic [13:0] saved_year_next;
    logic [6:0]  saved_hour_next;
    logic [6:0]  saved_minute_next;
    logic        digit_error_next;

    logic [2:0]  last_fi;
    logic [2:0]  fi_cur;
    role_t       role_cur;
    role_t       role_end;
    logic        is_sep;
    logic        is_digit;
    logic [16:0] acc_wide;
    logic [16:0] cap_wide;
    logic [13:0] year_cfg;

    // Apply one byte to the working state
    always_comb
    begin
        last_fi  = last_field(format_kind);
        fi_cur   = (field_index_reg > last_fi) ? last_fi : field_index_reg;
        role_cur = field_role(format_kind, fi_cur);
        is_sep   = (fi_cur < last_fi) && (char_code == field_sep(format_kind, fi_cur));
        is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        cap_wide = (role_cur == ROLE_YEAR) ? {3'b000, YEAR_CAP} : {3'b000, NUM_CAP};
        acc_wide = ({3'b000, acc_reg} << 3) + ({3'b000, acc_reg} << 1)
                 + {13'd0, char_code[3:0]};

        field_index_next  = fi_cur;
        acc_next          = acc_reg;
        month_text_next   = month_text_reg;
        month_len_next    = month_len_reg;
        saved_day_next    = saved_day_reg;
        saved_month_next  = saved_month_reg;
        saved_year_next   = saved_year_reg;
        saved_hour_next   = saved_hour_reg;
        saved_minute_next = saved_minute_reg;
        digit_error_next  = digit_error_reg;

        if (is_sep)
        begin
            case (role_cur)
                ROLE_DAY:  saved_day_next    = acc_reg[6:0];
                ROLE_MON:  saved_month_next  = decode_month(month_text_reg, month_len_reg);
                ROLE_YEAR: saved_year_next   = acc_reg;
                ROLE_HOUR: saved_hour_next   = acc_reg[6:0];
                ROLE_MIN:  saved_minute_next = acc_reg[6:0];
                default:   ;
            endcase
            acc_next         = '0;
            month_text_next  = '0;
            month_len_next   = '0;
            field_index_next = fi_cur + 3'd1;
        end
        else if (role_cur == ROLE_MON)
        begin
            month_text_next = {month_text_reg[15:0], char_code};
            if (month_len_reg < MONTH_LEN_OVER)
            begin
                month_len_next = month_len_reg + 3'd1;
            end
        end
        else if (is_digit)
        begin
            acc_next = (acc_wide > cap_wide) ? cap_wide[13:0] : acc_wide[13:0];
        end
        else
        begin
            digit_error_next = 1'b1;
        end
    end

    // Close the open field and assemble the result
    always_comb
    begin
        role_end = field_role(format_kind, field_index_next);
        year_cfg = (current_year > YEAR_CAP) ? YEAR_CAP : current_year;

        result.day    = (role_end == ROLE_DAY)  ? acc_next[6:0] : saved_day_next;
        result.month  = (role_end == ROLE_MON)
                      ? decode_month(month_text_next, month_len_next) : saved_month_next;
        result.hour   = (role_end == ROLE_HOUR) ? acc_next[6:0] : saved_hour_next;
        result.minute = (role_end == ROLE_MIN)  ? acc_next[6:0] : saved_minute_next;
        result.second = (role_end == ROLE_SEC)  ? acc_next[6:0] : 7'd0;
        result.bad_digit = digit_error_next;
        if (format_kind == FMT_SHELL)
        begin
            result.year = year_cfg;
        end
        else
        begin
            result.year = (role_end == ROLE_YEAR) ? acc_next : saved_year_next;
        end
    end

    // Working state; cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg  <= '0;
            acc_reg          <= '0;
            month_text_reg   <= '0;
            month_len_reg    <= '0;
            saved_day_reg    <= '0;
            saved_month_reg  <= '0;
            saved_year_reg   <= '0;
            saved_hour_reg   <= '0;
            saved_minute_reg <= '0;
            digit_error_reg  <= 1'b0;
        end
        else if (fire)
        begin
            if (is_last)
            begin
                field_index_reg  <= '0;
                acc_reg          <= '0;
                month_text_reg   <= '0;
                month_len_reg    <= '0;
                saved_day_reg    <= '0;
                saved_month_reg  <= '0;
                saved_year_reg   <= '0;
                saved_hour_reg   <= '0;
                saved_minute_reg <= '0;
                digit_error_reg  <= 1'b0;
            end
            else
            begin
                field_index_reg  <= field_index_next;
                acc_reg          <= acc_next;
                month_text_reg   <= month_text_next;
                month_len_reg    <= month_len_next;
                saved_day_reg    <= saved_day_next;
                saved_month_reg  <= saved_month_next;
                saved_year_reg   <= saved_year_next;
                saved_hour_reg   <= saved_hour_next;
                saved_minute_reg <= saved_minute_next;
                digit_error_reg  <= digit_error_next;
            end
        end
    end

`ifndef SYNTHESIS
    // Final byte leaves a clean parser
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_last) |=> (field_index_reg == 3'd0 && acc_reg == 14'd0
                               && digit_error_reg == 1'b0))
        else $error("parser state not cleared after final byte");

    // Field position never passes the web layout's last field
    a_fi_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_index_reg <= LAST_FIELD_WEB)
        else $error("field index out of range");

    // Month length saturates at four
    a_mlen_range: assert property (@(posedge clk) disable iff (!rst_n)
        month_len_reg <= MONTH_LEN_OVER)
        else $error("month text length out of range");

    // Idle cycles leave the state alone
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(field_index_reg) && $stable(acc_reg))
        else $error("parser state changed without a beat");
`endif

endmodule

// File: rtl/core/log_timestamp_parser.sv
// Log timestamp parser top level: byte input register, parser and result register.
//
// Takes a timestamp one byte a beat (tlast on its final byte) and gives one result
// beat per timestamp with day, month, year, hour, minute and second. One byte is taken
// every cycle while the input is not stalled: a byte goes into the input register, is
// then applied to the parser state, and on the final byte the result lands in the
// output register, so a result is valid once its final byte has passed the input
// register and the output register. A waiting result stalls the input only when the
// next final byte arrives behind it. Set format_kind and current_year only while no timestamp is in flight.
module log_timestamp_parser (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [13:0] cfg_wdata,
    // Byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,     // [7:0] char_code
    input  logic        s_axis_tlast,     // is_last
    // Result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] day, [10:7] month, [24:11] year, [31:25] hour, [38:32] minute,
    // [45:39] second, [47:46] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser      // bad_digit
);
    import lts_pkg::*;

    logic        format_kind_reg;
    logic [13:0] current_year_reg;
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    result_t     result;
    logic        fire;
    logic        in_take;

    // A byte moves on unless it closes a timestamp while a result still waits
    assign fire    = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_take = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_kind_reg  <= FMT_WEB;
            current_year_reg <= YEAR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FORMAT_KIND:  format_kind_reg  <= cfg_wdata[0];
                CFG_CURRENT_YEAR: current_year_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    lts_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .char_code    (in_char_reg),
        .is_last      (in_last_reg),
        .format_kind  (format_kind_reg),
        .current_year (current_year_reg),
        .result       (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_last_reg)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg.second, out_data_reg.minute,
                            out_data_reg.hour, out_data_reg.year,
                            out_data_reg.month, out_data_reg.day};
    assign m_axis_tuser  = out_data_reg.bad_digit;

`ifndef SYNTHESIS
    // Reported month is always a valid code
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:7] <= 4'd12))
        else $error("month out of range");

    // Reported year is always saturated
    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[24:11] <= YEAR_CAP))
        else $error("year not saturated");

    // An empty input register always takes a beat
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled while empty");

    // A final byte always produces a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last_reg) |=> m_axis_tvalid)
        else $error("final byte produced no result");
`endif

endmodule

// File: tb/sv/log_timestamp_parser_test.sv
// Self-checking testbench for the log timestamp parser: byte stream in, parsed fields out.
module log_timestamp_parser_test;
    import lts_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 155;
    localparam int PRINT_LIMIT  = 40;
    // Twelve month abbreviations, first letter of the first name in the top byte
    localparam logic [8*36-1:0] MONTH_ABBREV = "JanFebMarAprMayJunJulAugSepOctNovDec";

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = CFG_FORMAT_KIND;
    logic [13:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] char_code
    logic        s_axis_tlast = 1'b0;  // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [6:0] day, [10:7] month, [24:11] year, [31:25] hour, [38:32] minute,
    // [45:39] second, [47:46] zero
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;         // bad_digit

    // Parser shadow state and shadowed registers
    logic        layout_now = FMT_WEB;
    logic [13:0] year_now = YEAR_RESET;
    logic [2:0]  field_pos = '0;
    int          digit_sum = 0;
    logic [23:0] month_chars = '0;
    int          month_chars_len = 0;
    int          kept_day = 0;
    logic [3:0]  kept_month = '0;
    int          kept_year = 0;
    int          kept_hour = 0;
    int          kept_minute = 0;
    bit          saw_bad_digit = 1'b0;

    result_t     expected_stamps[$];
    logic [7:0]  stamp_text[$];

    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          bytes_sent = 0;
    int          stamps_checked = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    log_timestamp_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d stamps still pending",
                     cycle_count, expected_stamps.size());
            $display("log_timestamp_parser verification failed");
            $finish;
        end
    end

    // Result side backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH at stamp %0d: %s", stamps_checked, msg);
    endtask

    // ---------------- predictor ----------------

    function automatic role_t field_role_of(input logic fmt, input logic [2:0] idx);
        role_t r;
        r = ROLE_SEC;
        if (fmt == FMT_WEB)
        begin
            case (idx)
                3'd0:    r = ROLE_DAY;
                3'd1:    r = ROLE_MON;
                3'd2:    r = ROLE_YEAR;
                3'd3:    r = ROLE_HOUR;
                3'd4:    r = ROLE_MIN;
                default: r = ROLE_SEC;
            endcase
        end
        else
        begin
            case (idx)
                3'd0:    r = ROLE_MON;
                3'd1:    r = ROLE_DAY;
                3'd2:    r = ROLE_HOUR;
                3'd3:    r = ROLE_MIN;
                default: r = ROLE_SEC;
            endcase
        end
        return r;
    endfunction

    // Only meaningful below the layout's last field position
    function automatic logic [7:0] field_separator_of(input logic fmt, input logic [2:0] idx);
        if (fmt == FMT_WEB)
            return (idx < 3'd2) ? CH_SLASH : CH_COLON;
        return (idx < 3'd2) ? CH_SPACE : CH_COLON;
    endfunction

    function automatic logic [23:0] month_code(input int m);
        return MONTH_ABBREV[8*(33-3*m) +: 24];
    endfunction

    function automatic logic [3:0] month_number(input logic [23:0] text, input int len);
        logic [3:0] num;
        num = '0;
        if (len == MONTH_LEN_FULL)
        begin
            for (int m = 0; m < 12; m++)
            begin
                if (text == month_code(m))
                    num = 4'(m + 1);
            end
        end
        return num;
    endfunction

    task automatic close_parsed_field(input role_t r);
        case (r)
            ROLE_DAY:  kept_day = digit_sum;
            ROLE_MON:  kept_month = month_number(month_chars, month_chars_len);
            ROLE_YEAR: kept_year = digit_sum;
            ROLE_HOUR: kept_hour = digit_sum;
            ROLE_MIN:  kept_minute = digit_sum;
            default:   ;
        endcase
        digit_sum = 0;
        month_chars = '0;
        month_chars_len = 0;
    endtask

    // Applies one accepted byte; on the final byte queues the expected fields
    task automatic parse_timestamp_byte(input logic [7:0] ch, input bit is_final);
        logic [2:0] last_pos;
        role_t      r;
        int         cap;
        int         sec;
        result_t    stamp;
        last_pos = (layout_now == FMT_SHELL) ? LAST_FIELD_SHELL : LAST_FIELD_WEB;
        if (field_pos > last_pos)
            field_pos = last_pos;
        r = field_role_of(layout_now, field_pos);
        if (field_pos < last_pos && ch == field_separator_of(layout_now, field_pos))
        begin
            close_parsed_field(r);
            field_pos++;
        end
        else if (r == ROLE_MON)
        begin
            month_chars = {month_chars[15:0], ch};
            if (month_chars_len < MONTH_LEN_OVER)
                month_chars_len++;
        end
        else if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            cap = (r == ROLE_YEAR) ? int'(YEAR_CAP) : int'(NUM_CAP);
            digit_sum = digit_sum * 10 + int'(ch - CH_ZERO);
            if (digit_sum > cap)
                digit_sum = cap;
        end
        else
            saw_bad_digit = 1'b1;

        if (!is_final)
            return;

        r = field_role_of(layout_now, field_pos);
        sec = (r == ROLE_SEC) ? digit_sum : 0;
        close_parsed_field(r);
        stamp.day = 7'(kept_day);
        stamp.month = kept_month;
        if (layout_now == FMT_SHELL)
            stamp.year = (year_now > YEAR_CAP) ? YEAR_CAP : year_now;
        else
            stamp.year = 14'(kept_year);
        stamp.hour = 7'(kept_hour);
        stamp.minute = 7'(kept_minute);
        stamp.second = 7'(sec);
        stamp.bad_digit = saw_bad_digit;
        expected_stamps.push_back(stamp);

        field_pos = '0;
        digit_sum = 0;
        month_chars = '0;
        month_chars_len = 0;
        kept_day = 0;
        kept_month = '0;
        kept_year = 0;
        kept_hour = 0;
        kept_minute = 0;
        saw_bad_digit = 1'b0;
    endtask

    // ---------------- result checker ----------------

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_stamps.size() == 0)
                report_mismatch($sformatf("result beat with nothing pending, data %h",
                                          m_axis_tdata));
            else
            begin
                want = expected_stamps.pop_front();
                if (m_axis_tdata[6:0] !== want.day)
                    report_mismatch($sformatf("day %0d, want %0d",
                                              m_axis_tdata[6:0], want.day));
                if (m_axis_tdata[10:7] !== want.month)
                    report_mismatch($sformatf("month %0d, want %0d",
                                              m_axis_tdata[10:7], want.month));
                if (m_axis_tdata[24:11] !== want.year)
                    report_mismatch($sformatf("year %0d, want %0d",
                                              m_axis_tdata[24:11], want.year));
                if (m_axis_tdata[31:25] !== want.hour)
                    report_mismatch($sformatf("hour %0d, want %0d",
                                              m_axis_tdata[31:25], want.hour));
                if (m_axis_tdata[38:32] !== want.minute)
                    report_mismatch($sformatf("minute %0d, want %0d",
                                              m_axis_tdata[38:32], want.minute));
                if (m_axis_tdata[45:39] !== want.second)
                    report_mismatch($sformatf("second %0d, want %0d",
                                              m_axis_tdata[45:39], want.second));
                if (m_axis_tuser !== want.bad_digit)
                    report_mismatch($sformatf("bad_digit %b, want %b",
                                              m_axis_tuser, want.bad_digit));
                stamps_checked++;
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    // One byte beat, with random sender gaps in front of it
    task automatic send_char(input logic [7:0] ch, input bit is_final);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= is_final;
        do @(posedge clk); while (!s_axis_tready);
        parse_timestamp_byte(ch, is_final);
        bytes_sent++;
    endtask

    // Sends the staged text; tlast on its final byte unless left open
    task automatic send_stamp_text(input bit closed);
        for (int i = 0; i < stamp_text.size(); i++)
            send_char(stamp_text[i], closed && (i == stamp_text.size() - 1));
    endtask

    task automatic send_string(input string s, input bit closed);
        stamp_text.delete();
        for (int i = 0; i < s.len(); i++)
            stamp_text.push_back(s[i]);
        send_stamp_text(closed);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_stamps.size() != 0);
    endtask

    // Register writes only with the parser pipeline empty
    task automatic set_layout(input logic fmt, input logic [13:0] yr);
        hold_until_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_FORMAT_KIND;
        cfg_wdata <= {13'd0, fmt};
        @(posedge clk);
        cfg_addr  <= CFG_CURRENT_YEAR;
        cfg_wdata <= yr;
        @(posedge clk);
        cfg_we    <= 1'b0;
        layout_now = fmt;
        year_now = yr;
    endtask

    task automatic add_number(input bit is_year);
        int n;
        if ($urandom_range(99) < 85)
            n = is_year ? 4 : $urandom_range(1, 2);
        else
            n = $urandom_range(0, is_year ? 6 : 4);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 4)
                stamp_text.push_back(8'($urandom_range(255)));
            else
                stamp_text.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    task automatic add_month();
        logic [23:0] code;
        int          pick;
        int          n;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            code = month_code($urandom_range(11));
            stamp_text.push_back(code[23:16]);
            stamp_text.push_back(code[15:8]);
            stamp_text.push_back(code[7:0]);
        end
        else if (pick < 95)
        begin
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                stamp_text.push_back(8'($urandom_range(8'h41, 8'h7A)));
        end
        else
            stamp_text.push_back(8'($urandom_range(255)));
    endtask

    // Mostly well-formed stamps with random content, some broken or pure noise
    task automatic build_random_stamp(input logic fmt);
        int n;
        stamp_text.delete();
        if (fmt == FMT_WEB)
        begin
            add_number(1'b0);
            stamp_text.push_back(CH_SLASH);
            add_month();
            stamp_text.push_back(CH_SLASH);
            add_number(1'b1);
            stamp_text.push_back(CH_COLON);
        end
        else
        begin
            add_month();
            stamp_text.push_back(CH_SPACE);
            add_number(1'b0);
            stamp_text.push_back(CH_SPACE);
        end
        add_number(1'b0);
        stamp_text.push_back(CH_COLON);
        add_number(1'b0);
        stamp_text.push_back(CH_COLON);
        add_number(1'b0);

        if ($urandom_range(99) < 12)
        begin
            case ($urandom_range(3))
                0: stamp_text = stamp_text[0:$urandom_range(0, stamp_text.size() - 1)];
                1: stamp_text[$urandom_range(0, stamp_text.size() - 1)] =
                       8'($urandom_range(255));
                2: if (stamp_text.size() > 1)
                       stamp_text.delete($urandom_range(0, stamp_text.size() - 1));
                default:
                begin
                    stamp_text.delete();
                    n = $urandom_range(1, 10);
                    for (int i = 0; i < n; i++)
                        stamp_text.push_back(8'($urandom_range(255)));
                end
            endcase
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_defaults();
        send_string("31/Dec/1999:23:59:59", 1'b1);
    endtask

    task automatic test_web_extremes();
        set_layout(FMT_WEB, 14'd2000);
        send_string("999/Jan/123456:100:0:99999", 1'b1);
        send_string("0/Dec/0:0:0:0", 1'b1);
    endtask

    task automatic test_bad_digits();
        // Non-digits in numeric fields, separators inside the final field
        send_string("x1/May/20a3:04:05:06:07", 1'b1);
        stamp_text = '{8'hFF, CH_SLASH, 8'h80, CH_SLASH, 8'h00, CH_COLON, 8'h7F};
        send_stamp_text(1'b1);
    endtask

    task automatic test_month_names();
        logic [23:0] code;
        set_layout(FMT_SHELL, YEAR_RESET);
        for (int m = 0; m < 12; m++)
        begin
            code = month_code(m);
            stamp_text = '{code[23:16], code[15:8], code[7:0]};
            send_stamp_text(1'b1);
        end
        // Too long, wrong case, too short
        send_string("Sept 1", 1'b1);
        send_string("jan 2", 1'b1);
        send_string("Ja 3", 1'b1);
    endtask

    task automatic test_empty_fields();
        set_layout(FMT_WEB, 14'd0);
        send_string("/", 1'b1);
        send_string("//:::", 1'b1);
        send_string("7", 1'b1);
    endtask

    task automatic test_shell_layout();
        set_layout(FMT_SHELL, 14'h3FFF);
        send_string("Feb 29 1:2:3", 1'b1);
        set_layout(FMT_SHELL, 14'd0);
        send_string("Oct  5 10:20:30", 1'b1);
        set_layout(FMT_SHELL, YEAR_CAP);
        send_string("Dec 31 23:59:59", 1'b1);
    endtask

    // Layout changed while a stamp is half parsed
    task automatic test_layout_switch();
        set_layout(FMT_WEB, 14'd2000);
        send_string("12/Mar/2001:04:05:", 1'b0);
        set_layout(FMT_SHELL, 14'd1234);
        send_string("6", 1'b1);
        send_string("Apr 7 08:", 1'b0);
        set_layout(FMT_WEB, 14'd77);
        send_string("9:10:11", 1'b1);
    endtask

    task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                     input logic fmt, input logic [13:0] yr);
        int start_count;
        set_layout(fmt, yr);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        start_count = bytes_sent;
        while (bytes_sent - start_count < PHASE_BYTES)
        begin
            build_random_stamp(fmt);
            send_stamp_text(1'b1);
            if ($urandom_range(99) < 5)
                hold_until_drained();
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(0, 0, FMT_WEB, 14'd0);
        run_traffic_phase(0, 0, FMT_SHELL, 14'h3FFF);
        hold_until_drained();
        run_traffic_phase(72, 0, FMT_WEB, YEAR_CAP);
        run_traffic_phase(72, 0, FMT_SHELL, YEAR_CAP);
        run_traffic_phase(0, 72, FMT_SHELL, 14'd0);
        run_traffic_phase(0, 72, FMT_WEB, 14'($urandom_range(9999)));
        run_traffic_phase(18, 18, FMT_WEB, YEAR_RESET);
        run_traffic_phase(18, 18, FMT_SHELL, 14'($urandom_range(9999)));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_web_extremes();
        test_bad_digits();
        test_month_names();
        test_empty_fields();
        test_shell_layout();
        test_layout_switch();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_stamps.size() != 0);
        repeat (8) @(posedge clk);

        $display("Covered %0d byte beats and %0d parsed stamps in web and shell layouts,",
                 bytes_sent, stamps_checked);
        $display("with idle and stall mixes from none to 72 percent; %0d mismatches.",
                 error_count);
        if (error_count == 0)
            $display("log_timestamp_parser verification clean");
        else
            $display("log_timestamp_parser verification failed");
        $finish;
    end

endmodule
